[rtl/core/fra_pkg.sv]
// Shared types and constants of the first-fit range allocator.
`default_nettype none
package fra_pkg;

   localparam int POOL_DEPTH   = 4096;
   localparam int FREE_SLOTS   = 16;
   localparam int LIVE_ENTRIES = 64;

   localparam int SLOT_AW = $clog2(FREE_SLOTS);
   localparam int SLOT_CW = $clog2(FREE_SLOTS + 1);
   localparam int LIVE_AW = $clog2(LIVE_ENTRIES);
   localparam int LIVE_CW = $clog2(LIVE_ENTRIES + 1);

   localparam logic [12:0] POOL_MAX = 13'(POOL_DEPTH);

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EXHAUSTED  = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_LIST_FULL  = 3'd3,
      ST_UNKNOWN    = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [12:0] count;
      logic [11:0] handle;
   } req_type;

   typedef struct packed {
      logic [11:0] handle_out;
      status_type  status;
      logic [12:0] released;
      logic [12:0] high_water;
   } rsp_type;

   // One free slot or one live allocation: start and size
   typedef struct packed {
      logic [11:0] start;
      logic [12:0] size;
   } range_type;

   typedef enum logic [1:0] {
      SOP_NONE,
      SOP_WRITE,
      SOP_REMOVE,
      SOP_INSERT
   } slot_op_type;

   typedef struct packed {
      slot_op_type          op;
      logic [SLOT_AW-1:0]   addr;
      range_type            data;
   } slot_cmd_type;

   typedef struct packed {
      logic                 wr_en;
      logic [LIVE_AW-1:0]   wr_addr;
      range_type            wr_data;
      logic                 clr_en;
      logic [LIVE_AW-1:0]   clr_addr;
   } live_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_FREE,
      S_A_SLOT,
      S_A_BUMP,
      S_F_SCAN,
      S_F_POS,
      S_F_DECIDE,
      S_F_APPLY,
      S_F_JOIN,
      S_F_DROP,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

[rtl/core/fra_slot_file.sv]
// Sorted free-slot file with write, remove-and-shift and insert-and-shift operations.
`default_nettype none
module fra_slot_file (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fra_pkg::slot_cmd_type       cmd,
   input  wire logic [fra_pkg::SLOT_AW-1:0] rd_addr,
   output fra_pkg::range_type               rd_entry,
   output logic [fra_pkg::SLOT_CW-1:0]      count
);

   fra_pkg::range_type              entry_ff [fra_pkg::FREE_SLOTS];
   fra_pkg::range_type              entry_in [fra_pkg::FREE_SLOTS];
   logic [fra_pkg::SLOT_CW-1:0]     count_ff;
   logic [fra_pkg::SLOT_CW-1:0]     count_in;

   // Per-entry next value; each entry sees only its own neighbors
   for (genvar k = 0; k < fra_pkg::FREE_SLOTS; k++) begin : g_entry
      fra_pkg::range_type upper_nb;
      fra_pkg::range_type lower_nb;

      if (k + 1 < fra_pkg::FREE_SLOTS) begin : g_up
         assign upper_nb = entry_ff[k + 1];
      end else begin : g_up_last
         assign upper_nb = entry_ff[k];
      end
      if (k > 0) begin : g_lo
         assign lower_nb = entry_ff[k - 1];
      end else begin : g_lo_first
         assign lower_nb = entry_ff[k];
      end

      always_comb begin
         entry_in[k] = entry_ff[k];
         case (cmd.op)
            fra_pkg::SOP_WRITE: begin
               if (cmd.addr == fra_pkg::SLOT_AW'(k)) entry_in[k] = cmd.data;
            end
            fra_pkg::SOP_REMOVE: begin
               if (fra_pkg::SLOT_AW'(k) >= cmd.addr) entry_in[k] = upper_nb;
            end
            fra_pkg::SOP_INSERT: begin
               if (fra_pkg::SLOT_AW'(k) > cmd.addr) entry_in[k] = lower_nb;
               else if (cmd.addr == fra_pkg::SLOT_AW'(k)) entry_in[k] = cmd.data;
            end
            default: begin
               entry_in[k] = entry_ff[k];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         entry_ff[k] <= entry_in[k];
      end
   end

   // Fill count
   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         fra_pkg::SOP_REMOVE: count_in = count_ff - 1'b1;
         fra_pkg::SOP_INSERT: count_in = count_ff + 1'b1;
         default:             count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_entry = entry_ff[rd_addr];
   assign count    = count_ff;

endmodule
`default_nettype wire

[rtl/core/fra_live_table.sv]
// Live allocation table: start/size memory with registered read and per-entry valid flags.
`default_nettype none
module fra_live_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fra_pkg::live_cmd_type       cmd,
   input  wire logic [fra_pkg::LIVE_AW-1:0] rd_addr,
   output fra_pkg::range_type               rd_data,
   output logic [fra_pkg::LIVE_ENTRIES-1:0] valid
);

   fra_pkg::range_type                mem_ff [fra_pkg::LIVE_ENTRIES];
   fra_pkg::range_type                rd_data_ff;
   logic [fra_pkg::LIVE_ENTRIES-1:0]  valid_ff;
   logic [fra_pkg::LIVE_ENTRIES-1:0]  valid_in;

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem_ff[cmd.wr_addr] <= cmd.wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Valid flags: set on write, cleared on release
   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en)  valid_in[cmd.wr_addr]  = 1'b1;
      if (cmd.clr_en) valid_in[cmd.clr_addr] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule
`default_nettype wire

[rtl/core/first_fit_range_allocator_core.sv]
// Top level: request sequencer of the first-fit range allocator.
// Handles one request at a time and walks its tables one entry per cycle.
// An allocate first finds the first unused live entry, then visits the free
// slots up to the first one that fits (or all slots, then bump allocation),
// then posts the response. A free walks the live table through its single
// registered read port, one entry per cycle up to the match, then the free
// slots up to the insert position, then merges or inserts and posts the
// response. The input is ready again once the response is posted to the
// output register; a waiting response does not stall the acceptance of the
// next request, only the posting of its response.
// The configuration register is always ready and is meant to be written idle.
`default_nettype none
module first_fit_range_allocator_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fra_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fra_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [12:0]      csr_data
);

   fra_pkg::state_type              state_ff, state_in;
   fra_pkg::req_type                req_ff, req_in;
   logic [fra_pkg::LIVE_CW-1:0]     idx_ff, idx_in;
   logic                            pend_ff, pend_in;
   logic [fra_pkg::LIVE_AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [fra_pkg::LIVE_AW-1:0]     ent_ff, ent_in;
   logic [12:0]                     sz_ff, sz_in;
   logic [fra_pkg::SLOT_CW-1:0]     sidx_ff, sidx_in;
   logic [11:0]                     prev_start_ff, prev_start_in;
   logic [12:0]                     prev_size_ff, prev_size_in;
   logic [13:0]                     prev_end_ff, prev_end_in;
   logic                            left_ff, left_in;
   logic                            right_ff, right_in;
   logic [14:0]                     end_ff, end_in;
   logic [12:0]                     msize_ff, msize_in;
   fra_pkg::status_type             status_ff, status_in;
   logic [11:0]                     grant_ff, grant_in;
   logic [12:0]                     rel_ff, rel_in;
   logic [12:0]                     bump_ff, bump_in;
   logic [12:0]                     pool_limit_ff, pool_limit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   fra_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   fra_pkg::slot_cmd_type           slot_cmd;
   logic [fra_pkg::SLOT_AW-1:0]     slot_rd_addr;
   fra_pkg::range_type              slot_rd;
   logic [fra_pkg::SLOT_CW-1:0]     slot_cnt;
   fra_pkg::live_cmd_type           live_cmd;
   fra_pkg::range_type              live_rd;
   logic [fra_pkg::LIVE_ENTRIES-1:0] live_valid;

   fra_slot_file u_slots (
      .clock    (clock),
      .reset    (reset),
      .cmd      (slot_cmd),
      .rd_addr  (slot_rd_addr),
      .rd_entry (slot_rd),
      .count    (slot_cnt)
   );

   fra_live_table u_live (
      .clock   (clock),
      .reset   (reset),
      .cmd     (live_cmd),
      .rd_addr (idx_ff[fra_pkg::LIVE_AW-1:0]),
      .rd_data (live_rd),
      .valid   (live_valid)
   );

   // Sequencer: next state, datapath updates and table commands
   always_comb begin
      logic [12:0] lim;
      logic [13:0] bump_sum;
      logic [12:0] start_sum;
      logic [13:0] size_sum;
      logic [13:0] h_end;
      logic [fra_pkg::SLOT_AW-1:0] pos_m1;

      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      ent_in        = ent_ff;
      sz_in         = sz_ff;
      sidx_in       = sidx_ff;
      prev_start_in = prev_start_ff;
      prev_size_in  = prev_size_ff;
      prev_end_in   = prev_end_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      end_in        = end_ff;
      msize_in      = msize_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      rel_in        = rel_ff;
      bump_in       = bump_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      req_ready     = 1'b0;

      slot_rd_addr  = sidx_ff[fra_pkg::SLOT_AW-1:0];
      slot_cmd      = '0;
      live_cmd      = '0;

      lim       = (pool_limit_ff < fra_pkg::POOL_MAX) ? pool_limit_ff : fra_pkg::POOL_MAX;
      bump_sum  = {1'b0, bump_ff} + {1'b0, req_ff.count};
      start_sum = {1'b0, slot_rd.start} + req_ff.count;
      size_sum  = {1'b0, slot_rd.size} + {1'b0, sz_ff};
      h_end     = {2'b00, req_ff.handle} + {1'b0, sz_ff};
      pos_m1    = sidx_ff[fra_pkg::SLOT_AW-1:0] - 1'b1;

      case (state_ff)
         fra_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in  = req_data;
               idx_in  = '0;
               pend_in = 1'b0;
               state_in = (req_data.cmd == fra_pkg::CMD_FREE) ? fra_pkg::S_F_SCAN
                                                              : fra_pkg::S_A_FREE;
            end
         end

         // Allocate: find the first unused live entry
         fra_pkg::S_A_FREE: begin
            if (idx_ff == fra_pkg::LIVE_CW'(fra_pkg::LIVE_ENTRIES)) begin
               status_in = fra_pkg::ST_TABLE_FULL;
               grant_in  = '0;
               rel_in    = '0;
               state_in  = fra_pkg::S_RESP;
            end else if (!live_valid[idx_ff[fra_pkg::LIVE_AW-1:0]]) begin
               ent_in = idx_ff[fra_pkg::LIVE_AW-1:0];
               if (req_ff.count == '0) begin
                  status_in = fra_pkg::ST_EXHAUSTED;
                  grant_in  = '0;
                  rel_in    = '0;
                  state_in  = fra_pkg::S_RESP;
               end else begin
                  sidx_in  = '0;
                  state_in = fra_pkg::S_A_SLOT;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Allocate: first-fit walk over the free slots
         fra_pkg::S_A_SLOT: begin
            if (sidx_ff == slot_cnt) begin
               state_in = fra_pkg::S_A_BUMP;
            end else if (req_ff.count <= slot_rd.size) begin
               slot_cmd.addr = sidx_ff[fra_pkg::SLOT_AW-1:0];
               if (req_ff.count < slot_rd.size) begin
                  slot_cmd.op         = fra_pkg::SOP_WRITE;
                  slot_cmd.data.start = start_sum[11:0];
                  slot_cmd.data.size  = slot_rd.size - req_ff.count;
               end else begin
                  slot_cmd.op = fra_pkg::SOP_REMOVE;
               end
               live_cmd.wr_en         = 1'b1;
               live_cmd.wr_addr       = ent_ff;
               live_cmd.wr_data.start = slot_rd.start;
               live_cmd.wr_data.size  = req_ff.count;
               status_in = fra_pkg::ST_OK;
               grant_in  = slot_rd.start;
               rel_in    = '0;
               state_in  = fra_pkg::S_RESP;
            end else begin
               sidx_in = sidx_ff + 1'b1;
            end
         end

         // Allocate: bump the high-water index
         fra_pkg::S_A_BUMP: begin
            rel_in   = '0;
            state_in = fra_pkg::S_RESP;
            if (bump_sum > {1'b0, lim}) begin
               status_in = fra_pkg::ST_EXHAUSTED;
               grant_in  = '0;
            end else begin
               status_in              = fra_pkg::ST_OK;
               grant_in               = bump_ff[11:0];
               bump_in                = bump_sum[12:0];
               live_cmd.wr_en         = 1'b1;
               live_cmd.wr_addr       = ent_ff;
               live_cmd.wr_data.start = bump_ff[11:0];
               live_cmd.wr_data.size  = req_ff.count;
            end
         end

         // Free: look up the handle, one memory read per cycle
         fra_pkg::S_F_SCAN: begin
            if (pend_ff && live_valid[cmp_idx_ff] && live_rd.start == req_ff.handle) begin
               ent_in   = cmp_idx_ff;
               sz_in    = live_rd.size;
               sidx_in  = '0;
               state_in = fra_pkg::S_F_POS;
            end else if (idx_ff == fra_pkg::LIVE_CW'(fra_pkg::LIVE_ENTRIES)) begin
               status_in = fra_pkg::ST_UNKNOWN;
               grant_in  = req_ff.handle;
               rel_in    = '0;
               state_in  = fra_pkg::S_RESP;
            end else begin
               cmp_idx_in = idx_ff[fra_pkg::LIVE_AW-1:0];
               pend_in    = 1'b1;
               idx_in     = idx_ff + 1'b1;
            end
         end

         // Free: find the sorted position, keep the left neighbor
         fra_pkg::S_F_POS: begin
            if (sidx_ff == slot_cnt || slot_rd.start >= req_ff.handle) begin
               state_in = fra_pkg::S_F_DECIDE;
            end else begin
               prev_start_in = slot_rd.start;
               prev_size_in  = slot_rd.size;
               prev_end_in   = {2'b00, slot_rd.start} + {1'b0, slot_rd.size};
               sidx_in       = sidx_ff + 1'b1;
            end
         end

         // Free: classify merge with left, right, both or none
         fra_pkg::S_F_DECIDE: begin
            left_in  = (sidx_ff != '0) && (prev_end_ff == {2'b00, req_ff.handle});
            right_in = (sidx_ff != slot_cnt) && ({2'b00, slot_rd.start} == h_end);
            end_in   = {1'b0, prev_end_ff} + {2'b00, sz_ff};
            msize_in = prev_size_ff + sz_ff;
            state_in = fra_pkg::S_F_APPLY;
         end

         fra_pkg::S_F_APPLY: begin
            grant_in = req_ff.handle;
            if (left_ff) begin
               slot_cmd.op         = fra_pkg::SOP_WRITE;
               slot_cmd.addr       = pos_m1;
               slot_cmd.data.start = prev_start_ff;
               slot_cmd.data.size  = msize_ff;
               if (sidx_ff != slot_cnt && end_ff == {3'b000, slot_rd.start}) begin
                  state_in = fra_pkg::S_F_JOIN;
               end else begin
                  live_cmd.clr_en   = 1'b1;
                  live_cmd.clr_addr = ent_ff;
                  status_in = fra_pkg::ST_OK;
                  rel_in    = sz_ff;
                  state_in  = fra_pkg::S_RESP;
               end
            end else if (right_ff) begin
               slot_cmd.op         = fra_pkg::SOP_WRITE;
               slot_cmd.addr       = sidx_ff[fra_pkg::SLOT_AW-1:0];
               slot_cmd.data.start = req_ff.handle;
               slot_cmd.data.size  = size_sum[12:0];
               live_cmd.clr_en     = 1'b1;
               live_cmd.clr_addr   = ent_ff;
               status_in = fra_pkg::ST_OK;
               rel_in    = sz_ff;
               state_in  = fra_pkg::S_RESP;
            end else if (slot_cnt == fra_pkg::SLOT_CW'(fra_pkg::FREE_SLOTS)) begin
               status_in = fra_pkg::ST_LIST_FULL;
               rel_in    = '0;
               state_in  = fra_pkg::S_RESP;
            end else begin
               slot_cmd.op         = fra_pkg::SOP_INSERT;
               slot_cmd.addr       = sidx_ff[fra_pkg::SLOT_AW-1:0];
               slot_cmd.data.start = req_ff.handle;
               slot_cmd.data.size  = sz_ff;
               live_cmd.clr_en     = 1'b1;
               live_cmd.clr_addr   = ent_ff;
               status_in = fra_pkg::ST_OK;
               rel_in    = sz_ff;
               state_in  = fra_pkg::S_RESP;
            end
         end

         // Free: both neighbors touch, absorb the right slot
         fra_pkg::S_F_JOIN: begin
            slot_cmd.op         = fra_pkg::SOP_WRITE;
            slot_cmd.addr       = pos_m1;
            slot_cmd.data.start = prev_start_ff;
            slot_cmd.data.size  = msize_ff + slot_rd.size;
            state_in            = fra_pkg::S_F_DROP;
         end

         fra_pkg::S_F_DROP: begin
            slot_cmd.op       = fra_pkg::SOP_REMOVE;
            slot_cmd.addr     = sidx_ff[fra_pkg::SLOT_AW-1:0];
            live_cmd.clr_en   = 1'b1;
            live_cmd.clr_addr = ent_ff;
            status_in = fra_pkg::ST_OK;
            rel_in    = sz_ff;
            state_in  = fra_pkg::S_RESP;
         end

         // Post the response once the output register is free
         fra_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.handle_out  = grant_ff;
               rsp_data_in.status      = status_ff;
               rsp_data_in.released    = rel_ff;
               rsp_data_in.high_water  = bump_ff;
               state_in                = fra_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fra_pkg::S_IDLE;
         end
      endcase
   end

   // Configuration register
   always_comb begin
      pool_limit_in = pool_limit_ff;
      if (csr_valid) pool_limit_in = csr_data;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fra_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         bump_ff       <= '0;
         pool_limit_ff <= fra_pkg::POOL_MAX;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         bump_ff       <= bump_in;
         pool_limit_ff <= pool_limit_in;
         pend_ff       <= pend_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      ent_ff        <= ent_in;
      sz_ff         <= sz_in;
      sidx_ff       <= sidx_in;
      prev_start_ff <= prev_start_in;
      prev_size_ff  <= prev_size_in;
      prev_end_ff   <= prev_end_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      end_ff        <= end_in;
      msize_ff      <= msize_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rel_ff        <= rel_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
